/* hw/rtl/vmss_pkg.sv */
// vmss_pkg: shared types and constants for the von Mises stress summer.
// No dependencies.
package vmss_pkg;
    localparam int unsigned NUM_COMP = 9;
    localparam int unsigned SQ_BITS  = 64;   // one squared 32-bit magnitude
    localparam int unsigned N_BITS   = 68;   // 3*sum - trace^2 headroom
    localparam int unsigned ROOT_BITS = 34;

    typedef logic signed [31:0] comp_t;
endpackage

/* hw/rtl/von_mises_stress_summer_top.sv */
// von_mises_stress_summer_top: nine accumulator lanes, norm merge, square root.
// Depends on vmss_pkg, vmss_lane, vmss_sqrt.
//
// Usage: each input item carries one 3x3 Q16.16 tensor plus group bits in
// s_tuser and the particle end marker in s_tlast. Non-last items are added
// into the lanes with s_tready left high. A last item triggers the result:
// the nine lanes square their sums in parallel, a merge stage forms
// (3*sum - trace^2)/2 over two registered steps, and a shared square-root
// unit yields one bit per cycle. m_tvalid rises once the root unit signals
// done, and the block takes no new item until that result has been taken.
// A group miss gives an all-zero result (still through the same path).
// Reset (aresetn low, synchronous) clears the lanes, sets group_select to 1
// and drops m_tvalid. While the receiver stalls, the result is held in its
// output register and s_tready stays low.
module von_mises_stress_summer_top
    import vmss_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,  // t_xx,t_xy,t_xz,t_yx,t_yy,t_yz,t_zx,t_zy,t_zz
    input  logic [31:0]  s_tuser,  // group_bits
    input  logic         s_tlast,  // last_of_particle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [231:0] m_tdata   // sum_xx,sum_yy,sum_zz,sum_xy,sum_xz,sum_yz,von_mises,pad
);
    typedef enum logic [2:0] {S_IDLE, S_SQ, S_MRG, S_ROOT, S_OUT} state_t;
    state_t state_reg;

    logic [31:0] gsel_reg;
    logic        hit_reg;
    logic        accept, sq_start, done;
    logic [8:0][31:0] accs;
    logic [8:0][SQ_BITS-1:0] sqs;
    logic [8:0][SQ_BITS-1:0] sq_reg;
    logic signed [33:0] tr_reg;
    logic [67:0] sumsq_reg, t2_reg, rad_reg;
    logic [33:0] trmag, root;
    logic [5:0][31:0] emit_reg;
    logic [33:0] vm_reg;
    logic clr;
    logic [67:0] sum_all;
    logic root_go_reg;
    logic start_q;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign clr      = (state_reg == S_SQ);

    for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
        vmss_lane u_lane (
            .aclk(aclk), .aresetn(aresetn), .add_en(accept), .clr(clr),
            .din(s_tdata[g*32 +: 32]), .acc(accs[g]), .sq(sqs[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) gsel_reg <= 32'd1;
        else if (cfg_wr_en) gsel_reg <= cfg_wr_data;
    end

    // Merge: sum of squares and trace^2, registered before the root.
    always_comb begin
        sum_all = '0;
        for (int i = 0; i < NUM_COMP; i++) sum_all = sum_all + 68'(sq_reg[i]);
    end
    assign trmag = tr_reg[33] ? (34'd0 - tr_reg) : tr_reg;

    vmss_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(rad_reg), .done(done), .root(root)
    );
    // root unit runs once the radicand register has loaded
    assign sq_start = start_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_tvalid    <= 1'b0;
            root_go_reg <= 1'b0;
        end else begin
            root_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (accept && s_tlast) begin
                    hit_reg   <= |(s_tuser & gsel_reg);
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    sq_reg <= sqs;
                    tr_reg <= 34'(signed'(accs[0])) + 34'(signed'(accs[4]))
                              + 34'(signed'(accs[8]));
                    emit_reg <= {accs[5], accs[2], accs[1], accs[8], accs[4], accs[0]};
                    state_reg <= S_MRG;
                end
                S_MRG: begin
                    sumsq_reg   <= sum_all;
                    t2_reg      <= 68'(trmag) * 68'(trmag);
                    root_go_reg <= 1'b1;
                    state_reg   <= S_ROOT;
                end
                S_ROOT: if (done) begin
                    vm_reg    <= hit_reg ? root : '0;
                    if (!hit_reg) emit_reg <= '0;
                    m_tvalid  <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) begin
                    m_tvalid  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // radicand = (3*sumsq - t2)/2, formed as the root starts
    always_ff @(posedge aclk) begin
        if (!aresetn) start_q <= 1'b0;
        else start_q <= root_go_reg;
        if (root_go_reg) rad_reg <= 68'((3 * 70'(sumsq_reg) - 70'(t2_reg)) >> 1);
    end

    assign m_tdata = {6'd0, vm_reg, emit_reg};
endmodule

/* hw/rtl/vmss_lane.sv */
// vmss_lane: one saturating accumulator lane and its squared magnitude.
// Depends on vmss_pkg.
module vmss_lane
    import vmss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        add_en,
    input  logic        clr,
    input  comp_t       din,
    output comp_t       acc,
    output logic [SQ_BITS-1:0] sq
);
    comp_t acc_reg, acc_next;
    logic signed [32:0] sum;
    logic [31:0] mag;

    always_comb begin
        sum = {acc_reg[31], acc_reg} + {din[31], din};
        if (sum > 33'sh0_7FFF_FFFF)       acc_next = 32'sh7FFF_FFFF;
        else if (sum < -33'sh0_8000_0000) acc_next = 32'sh8000_0000;
        else                              acc_next = sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            acc_reg <= '0;
        end else if (add_en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
    assign mag = acc_reg[31] ? (32'd0 - acc_reg) : acc_reg;
    assign sq  = 64'(mag) * 64'(mag);
endmodule

/* hw/rtl/vmss_sqrt.sv */
// vmss_sqrt: restoring integer square root, one result bit per cycle.
// Depends on vmss_pkg.
module vmss_sqrt
    import vmss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [N_BITS-1:0]    radicand,
    output logic                 done,
    output logic [ROOT_BITS-1:0] root
);
    logic [N_BITS-1:0]    x_reg;     // radicand bits still to bring down
    logic [ROOT_BITS+2:0] rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg, done_reg;
    logic [ROOT_BITS+2:0] rem_sh;
    logic [ROOT_BITS+2:0] trial;

    // remainder stays below 2*root+1, so its low ROOT_BITS+1 bits suffice
    always_comb begin
        rem_sh = {rem_reg[ROOT_BITS:0], x_reg[N_BITS-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                x_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'(ROOT_BITS - 1);
            end else if (busy_reg) begin
                x_reg <= x_reg << 2;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
